[src/ppush_pkg.sv]
// Package for the 1D particle push pipeline: widths, fixed-point constants,
// register indexes, stage payload types and the cell-locate helper.
// No dependencies; every other file of the block imports it.
package ppush_pkg;

    // Grid and number format.
    localparam int MAX_CELLS = 1024;
    localparam int FRAC_BITS = 16;
    localparam int CELL_W    = $clog2(MAX_CELLS);
    localparam int CNT_W     = CELL_W + 1;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int CHI_W     = PROD_W - 2 * FRAC_BITS;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    // Configuration port.
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_CELLS_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP      = 3'd0,
        REG_DOMAIN_LENGTH  = 3'd1,
        REG_INV_CELL_WIDTH = 3'd2,
        REG_NUM_CELLS      = 3'd3,
        REG_ACCEL_FACTOR   = 3'd4
    } cfg_reg_t;

    // Request type codes.
    localparam logic REQ_FIELD_LOAD = 1'b0;
    localparam logic REQ_PUSH       = 1'b1;

    // Settings as the datapath sees them.
    typedef struct packed {
        logic [WORD_W-1:0] time_step;
        logic [WORD_W:0]   domain_len;     // zero register reads as 2^32
        logic [WORD_W-1:0] inv_cell_width;
        logic [CNT_W-1:0]  cells;          // clamped to 1..MAX_CELLS
        logic [WORD_W-1:0] accel_factor;
    } cfg_t;

    // Input beat.
    typedef struct packed {
        logic              req_type;
        logic [CELL_W-1:0] field_index;
        logic [WORD_W-1:0] field_value;
        logic [WORD_W-1:0] pos_in;
        logic [WORD_W-1:0] vel_in;
    } req_t;

    // Gather stage result: particle plus interpolated field.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] vel;
        logic [WORD_W-1:0] efield;
    } gat_t;

    // Advance stage result: new position and velocity.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] pos;
        logic [WORD_W-1:0] vel;
    } adv_t;

    // Output beat.
    typedef struct packed {
        logic [WORD_W-1:0]    pos_out;
        logic [WORD_W-1:0]    vel_out;
        logic [CELL_W-1:0]    cell_index;
        logic [CELL_W-1:0]    next_cell_index;
        logic [FRAC_BITS-1:0] upper_weight;
        logic [WGT_W-1:0]     lower_weight;
    } rsp_t;

    // Lower cell, upper cell and fraction.
    typedef struct packed {
        logic [CELL_W-1:0]    lo;
        logic [CELL_W-1:0]    hi;
        logic [FRAC_BITS-1:0] frac;
    } cell_loc_t;

    // Clamp the programmed cell count to 1..MAX_CELLS.
    function automatic logic [CNT_W-1:0] cells_in_use(input logic [NUM_CELLS_W-1:0] n);
        logic [CNT_W-1:0] r;
        if (n == '0)
            r = CNT_W'(1);
        else if (32'(n) > 32'(MAX_CELLS))
            r = CNT_W'(MAX_CELLS);
        else
            r = CNT_W'(n);
        return r;
    endfunction

    // Split position times 1/dx into cell pair and fraction. A cell past the
    // grid saturates to the last cell, whose upper neighbor is cell 0.
    function automatic cell_loc_t locate(input logic [PROD_W-1:0] prod,
                                         input logic [CNT_W-1:0] n);
        logic [CHI_W-1:0] c;
        logic [CNT_W-1:0] lo_w;
        logic [CNT_W-1:0] lo_inc;
        cell_loc_t        r;
        c = prod[PROD_W-1 -: CHI_W];
        if (PROD_W'(c) >= PROD_W'(n))
            lo_w = n - CNT_W'(1);
        else
            lo_w = c[CNT_W-1:0];
        lo_inc = lo_w + CNT_W'(1);
        r.lo   = lo_w[CELL_W-1:0];
        r.hi   = (lo_inc >= n) ? '0 : lo_inc[CELL_W-1:0];
        r.frac = prod[2*FRAC_BITS-1:FRAC_BITS];
        return r;
    endfunction

    // Weight of the lower cell: one minus the fraction.
    function automatic logic [WGT_W-1:0] lower_weight_of(input logic [FRAC_BITS-1:0] frac);
        return WGT_W'(ONE_Q) - {1'b0, frac};
    endfunction

endpackage

[src/ppush_req_if.sv]
// Request channel: valid/ready handshake carrying one field load or push.
// Depends on ppush_pkg for field widths.
interface ppush_req_if;
    import ppush_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CELL_W-1:0] field_index;
    logic [WORD_W-1:0] field_value;
    logic [WORD_W-1:0] pos_in;
    logic [WORD_W-1:0] vel_in;

    modport source (output valid, req_type, field_index, field_value, pos_in, vel_in,
                    input ready);
    modport sink   (input valid, req_type, field_index, field_value, pos_in, vel_in,
                    output ready);
endinterface

[src/ppush_rsp_if.sv]
// Result channel: valid/ready handshake carrying one pushed particle.
// Depends on ppush_pkg for field widths.
interface ppush_rsp_if;
    import ppush_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    pos_out;
    logic [WORD_W-1:0]    vel_out;
    logic [CELL_W-1:0]    cell_index;
    logic [CELL_W-1:0]    next_cell_index;
    logic [FRAC_BITS-1:0] upper_weight;
    logic [WGT_W-1:0]     lower_weight;

    modport source (output valid, pos_out, vel_out, cell_index, next_cell_index,
                    upper_weight, lower_weight, input ready);
    modport sink   (input valid, pos_out, vel_out, cell_index, next_cell_index,
                    upper_weight, lower_weight, output ready);
endinterface

[src/pic_particle_push_1d.sv]
// 1D particle-in-cell push, leapfrog order with cloud-in-cell weights, Q16.16.
// Accepts one beat per cycle while the output register is empty or being taken;
// twelve register stages all advance together, and the field store reads both
// cells of a particle in the same cycle on two ports.
// Reset clears the valid bits and loads register defaults; the field store is
// not cleared and reads undefined until written.
module pic_particle_push_1d (
    input  logic                                clk,
    input  logic                                rst_n,
    ppush_req_if.sink                           in_ch,
    ppush_rsp_if.source                         out_ch,
    input  logic                                cfg_we,
    input  logic [ppush_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppush_pkg::WORD_W-1:0]        cfg_data
);
    import ppush_pkg::*;

    logic [WORD_W-1:0]      time_step_reg;
    logic [WORD_W-1:0]      domain_length_reg;
    logic [WORD_W-1:0]      inv_cell_width_reg;
    logic [NUM_CELLS_W-1:0] num_cells_reg;
    logic [WORD_W-1:0]      accel_factor_reg;

    cfg_t cfg;
    req_t req;
    gat_t gat;
    adv_t adv;
    rsp_t rsp;
    logic rsp_valid;
    logic en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg      <= '0;
            domain_length_reg  <= WORD_W'(ONE_Q);
            inv_cell_width_reg <= WORD_W'(ONE_Q);
            num_cells_reg      <= NUM_CELLS_W'(MAX_CELLS);
            accel_factor_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TIME_STEP:      time_step_reg      <= cfg_data;
                REG_DOMAIN_LENGTH:  domain_length_reg  <= cfg_data;
                REG_INV_CELL_WIDTH: inv_cell_width_reg <= cfg_data;
                REG_NUM_CELLS:      num_cells_reg      <= cfg_data[NUM_CELLS_W-1:0];
                REG_ACCEL_FACTOR:   accel_factor_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Settings as used by the datapath.
    assign cfg.time_step      = time_step_reg;
    assign cfg.domain_len     = (domain_length_reg == '0) ? {1'b1, WORD_W'(0)}
                                                          : {1'b0, domain_length_reg};
    assign cfg.inv_cell_width = inv_cell_width_reg;
    assign cfg.cells          = cells_in_use(num_cells_reg);
    assign cfg.accel_factor   = accel_factor_reg;

    // The whole pipeline moves when the output register is empty or being taken.
    assign en          = !rsp_valid || out_ch.ready;
    assign in_ch.ready = en;

    assign req.req_type    = in_ch.req_type;
    assign req.field_index = in_ch.field_index;
    assign req.field_value = in_ch.field_value;
    assign req.pos_in      = in_ch.pos_in;
    assign req.vel_in      = in_ch.vel_in;

    ppush_gather u_gather (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (in_ch.valid),
        .req       (req),
        .cfg       (cfg),
        .gat       (gat)
    );

    ppush_advance u_advance (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .gat   (gat),
        .cfg   (cfg),
        .adv   (adv)
    );

    ppush_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .adv       (adv),
        .cfg       (cfg),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    assign out_ch.valid           = rsp_valid;
    assign out_ch.pos_out         = rsp.pos_out;
    assign out_ch.vel_out         = rsp.vel_out;
    assign out_ch.cell_index      = rsp.cell_index;
    assign out_ch.next_cell_index = rsp.next_cell_index;
    assign out_ch.upper_weight    = rsp.upper_weight;
    assign out_ch.lower_weight    = rsp.lower_weight;

    // The two cloud-in-cell weights always sum to one.
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (({1'b0, rsp.upper_weight} + rsp.lower_weight) == WGT_W'(ONE_Q)))
        else $error("cell weights do not sum to one");

    // Both reported cells lie inside the grid in use.
    a_cells_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((CNT_W'(rsp.cell_index) < cfg.cells)
                       && (CNT_W'(rsp.next_cell_index) < cfg.cells)))
        else $error("reported cell outside the grid");

    // The wrapped position lies inside the periodic domain.
    a_pos_in_domain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp.pos_out} < cfg.domain_len))
        else $error("position outside the domain");

endmodule

[src/ppush_gather.sv]
// Front four pipeline stages: locate at the incoming position, field store
// (one write port, two read ports), weighting products and field sum.
// Depends on ppush_pkg.
module ppush_gather (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            req_valid,
    input  ppush_pkg::req_t req,
    input  ppush_pkg::cfg_t cfg,
    output ppush_pkg::gat_t gat
);
    import ppush_pkg::*;

    localparam int PW = WORD_W + FRAC_BITS + 2;

    // Stage 1: captured beat and position times 1/dx.
    logic              s1_valid_reg;
    logic              s1_load_reg;
    logic [CELL_W-1:0] s1_idx_reg;
    logic [WORD_W-1:0] s1_fval_reg;
    logic [WORD_W-1:0] s1_pos_reg;
    logic [WORD_W-1:0] s1_vel_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [PROD_W-1:0] s1_prod_next;

    // Stage 2: cell fraction and the two field samples.
    logic                 s2_valid_reg;
    logic [WORD_W-1:0]    s2_pos_reg;
    logic [WORD_W-1:0]    s2_vel_reg;
    logic [FRAC_BITS-1:0] s2_frac_reg;
    logic [WORD_W-1:0]    rd_lo_reg;
    logic [WORD_W-1:0]    rd_hi_reg;

    // Stage 3: weighted samples.
    logic                 s3_valid_reg;
    logic [WORD_W-1:0]    s3_pos_reg;
    logic [WORD_W-1:0]    s3_vel_reg;
    logic signed [PW-1:0] prod_lo_reg;
    logic signed [PW-1:0] prod_hi_reg;
    logic signed [PW-1:0] prod_lo_next;
    logic signed [PW-1:0] prod_hi_next;

    // Stage 4: interpolated field.
    logic              s4_valid_reg;
    logic [WORD_W-1:0] s4_pos_reg;
    logic [WORD_W-1:0] s4_vel_reg;
    logic [WORD_W-1:0] e_reg;
    logic [WORD_W-1:0] e_next;

    logic [WORD_W-1:0] field_mem [MAX_CELLS];
    cell_loc_t         loc;
    logic              wr_en;
    logic [WGT_W-1:0]  w_lo;
    logic signed [PW:0] e_sum;
    logic signed [PW:0] e_shift;

    assign s1_prod_next = PROD_W'(req.pos_in) * PROD_W'(cfg.inv_cell_width);

    // Cell lookup between stage 1 and the store read.
    assign loc   = locate(s1_prod_reg, cfg.cells);
    assign wr_en = en && s1_valid_reg && (s1_load_reg == REQ_FIELD_LOAD)
                   && (PROD_W'(s1_idx_reg) < PROD_W'(MAX_CELLS));

    // Field loads write at the same stage where pushes read, so program order
    // between loads and pushes is kept.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            field_mem[s1_idx_reg] <= s1_fval_reg;
        end
        if (en)
        begin
            rd_lo_reg <= field_mem[loc.lo];
            rd_hi_reg <= field_mem[loc.hi];
        end
    end

    // Weighting products of the two samples.
    always_comb
    begin
        w_lo         = lower_weight_of(s2_frac_reg);
        prod_lo_next = PW'($signed(rd_lo_reg)) * PW'($signed({1'b0, w_lo}));
        prod_hi_next = PW'($signed(rd_hi_reg)) * PW'($signed({2'b0, s2_frac_reg}));
        e_sum        = (PW+1)'(prod_lo_reg) + (PW+1)'(prod_hi_reg);
        e_shift      = e_sum >>> FRAC_BITS;
        e_next       = e_shift[WORD_W-1:0];
    end

    // Valid bits; a field load leaves the pipeline after stage 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg && (s1_load_reg == REQ_PUSH);
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_load_reg <= req.req_type;
            s1_idx_reg  <= req.field_index;
            s1_fval_reg <= req.field_value;
            s1_pos_reg  <= req.pos_in;
            s1_vel_reg  <= req.vel_in;
            s1_prod_reg <= s1_prod_next;
            s2_pos_reg  <= s1_pos_reg;
            s2_vel_reg  <= s1_vel_reg;
            s2_frac_reg <= loc.frac;
            s3_pos_reg  <= s2_pos_reg;
            s3_vel_reg  <= s2_vel_reg;
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            s4_pos_reg  <= s3_pos_reg;
            s4_vel_reg  <= s3_vel_reg;
            e_reg       <= e_next;
        end
    end

    assign gat.valid  = s4_valid_reg;
    assign gat.pos    = s4_pos_reg;
    assign gat.vel    = s4_vel_reg;
    assign gat.efield = e_reg;

endmodule

[src/ppush_advance.sv]
// Middle six pipeline stages: velocity kick with saturation, displacement,
// single periodic wrap and clamp into the domain.
// Depends on ppush_pkg.
module ppush_advance (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ppush_pkg::gat_t gat,
    input  ppush_pkg::cfg_t cfg,
    output ppush_pkg::adv_t adv
);
    import ppush_pkg::*;

    localparam int VW = PROD_W + 1;
    localparam logic signed [VW-1:0] V_MAX = 65'sd2147483647;
    localparam logic signed [VW-1:0] V_MIN = -65'sd2147483648;

    // Stage 5: accel_factor times field.
    logic                     s5_valid_reg;
    logic [WORD_W-1:0]        s5_pos_reg;
    logic [WORD_W-1:0]        s5_vel_reg;
    logic signed [PROD_W-1:0] acc_prod_reg;
    logic signed [PROD_W-1:0] acc_prod_next;

    // Stage 6: new velocity.
    logic              s6_valid_reg;
    logic [WORD_W-1:0] s6_pos_reg;
    logic [WORD_W-1:0] v6_reg;
    logic [WORD_W-1:0] v6_next;

    // Stage 7: velocity times dt.
    logic                 s7_valid_reg;
    logic [WORD_W-1:0]    s7_pos_reg;
    logic [WORD_W-1:0]    v7_reg;
    logic signed [VW-1:0] dprod_reg;
    logic signed [VW-1:0] dprod_next;

    // Stage 8: raw new position.
    logic                 s8_valid_reg;
    logic [WORD_W-1:0]    v8_reg;
    logic signed [VW-1:0] p8_reg;
    logic signed [VW-1:0] p8_next;

    // Stage 9: wrapped once.
    logic                 s9_valid_reg;
    logic [WORD_W-1:0]    v9_reg;
    logic signed [VW-1:0] p9_reg;
    logic signed [VW-1:0] p9_next;

    // Stage 10: clamped into the domain.
    logic              s10_valid_reg;
    logic [WORD_W-1:0] v10_reg;
    logic [WORD_W-1:0] p10_reg;
    logic [WORD_W-1:0] p10_next;

    logic signed [VW-1:0] vsum;
    logic signed [VW-1:0] len_s;
    logic [WORD_W:0]      len_m1;

    // Datapath between the stage registers.
    always_comb
    begin
        acc_prod_next = PROD_W'($signed(cfg.accel_factor)) * PROD_W'($signed(gat.efield));

        vsum = VW'($signed(s5_vel_reg)) + VW'(acc_prod_reg >>> FRAC_BITS);
        if (vsum > V_MAX)
            v6_next = 32'h7FFF_FFFF;
        else if (vsum < V_MIN)
            v6_next = 32'h8000_0000;
        else
            v6_next = vsum[WORD_W-1:0];

        dprod_next = VW'($signed(v6_reg)) * $signed({(VW-WORD_W)'(0), cfg.time_step});
        p8_next    = $signed({(VW-WORD_W)'(0), s7_pos_reg}) + (dprod_reg >>> FRAC_BITS);

        len_s  = $signed({(VW-WORD_W-1)'(0), cfg.domain_len});
        len_m1 = cfg.domain_len - (WORD_W+1)'(1);
        if (p8_reg >= len_s)
            p9_next = p8_reg - len_s;
        else if (p8_reg < 0)
            p9_next = p8_reg + len_s;
        else
            p9_next = p8_reg;

        if (p9_reg < 0)
            p10_next = '0;
        else if (p9_reg >= len_s)
            p10_next = len_m1[WORD_W-1:0];
        else
            p10_next = p9_reg[WORD_W-1:0];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg  <= gat.valid;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_pos_reg   <= gat.pos;
            s5_vel_reg   <= gat.vel;
            acc_prod_reg <= acc_prod_next;
            s6_pos_reg   <= s5_pos_reg;
            v6_reg       <= v6_next;
            s7_pos_reg   <= s6_pos_reg;
            v7_reg       <= v6_reg;
            dprod_reg    <= dprod_next;
            v8_reg       <= v7_reg;
            p8_reg       <= p8_next;
            v9_reg       <= v8_reg;
            p9_reg       <= p9_next;
            v10_reg      <= v9_reg;
            p10_reg      <= p10_next;
        end
    end

    assign adv.valid = s10_valid_reg;
    assign adv.pos   = p10_reg;
    assign adv.vel   = v10_reg;

endmodule

[src/ppush_output.sv]
// Last two pipeline stages: locate at the new position and the output
// register that holds a result beat until it is taken.
// Depends on ppush_pkg.
module ppush_output (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ppush_pkg::adv_t adv,
    input  ppush_pkg::cfg_t cfg,
    output logic            rsp_valid,
    output ppush_pkg::rsp_t rsp
);
    import ppush_pkg::*;

    // Stage 11: new position times 1/dx.
    logic              s11_valid_reg;
    logic [WORD_W-1:0] s11_pos_reg;
    logic [WORD_W-1:0] s11_vel_reg;
    logic [PROD_W-1:0] s11_prod_reg;
    logic [PROD_W-1:0] s11_prod_next;

    // Stage 12: output register.
    logic      out_valid_reg;
    rsp_t      rsp_reg;
    rsp_t      rsp_next;
    cell_loc_t loc;

    // Cell pair and weights of the new position.
    always_comb
    begin
        s11_prod_next            = PROD_W'(adv.pos) * PROD_W'(cfg.inv_cell_width);
        loc                      = locate(s11_prod_reg, cfg.cells);
        rsp_next.pos_out         = s11_pos_reg;
        rsp_next.vel_out         = s11_vel_reg;
        rsp_next.cell_index      = loc.lo;
        rsp_next.next_cell_index = loc.hi;
        rsp_next.upper_weight    = loc.frac;
        rsp_next.lower_weight    = lower_weight_of(loc.frac);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s11_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s11_valid_reg <= adv.valid;
            out_valid_reg <= s11_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_pos_reg  <= adv.pos;
            s11_vel_reg  <= adv.vel;
            s11_prod_reg <= s11_prod_next;
            rsp_reg      <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule
